// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgMsW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StatusW = 2;

  // Register reset values.
  localparam logic [CfgMsW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgMsW-1:0] ClickMinRst  = 16'd50;
  localparam logic [CfgMsW-1:0] LongPressRst = 16'd1000;
  localparam logic              ActiveHighRst = 1'b0;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_CLICK_MIN  = 2'd1,
    CFG_LONG_PRESS = 2'd2,
    CFG_ACTIVE_HI  = 2'd3
  } cfg_idx_e;

  // Status codes reported in the result.
  localparam logic [StatusW-1:0] STATUS_RELEASED = 2'd0;
  localparam logic [StatusW-1:0] STATUS_PRESSED  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_LONG     = 2'd2;

  // Internal button state, one-hot.
  typedef enum logic [2:0] {
    ST_RELEASED = 3'b001,
    ST_PRESSED  = 3'b010,
    ST_LONG     = 3'b100
  } press_state_e;

  typedef struct packed {
    logic              pin_changed;
    logic              pin_level;
    logic [TimeW-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic               down_event;
    logic               up_event;
    logic               click_event;
    logic               long_event;
    logic [StatusW-1:0] button_status;
  } out_item_t;

  typedef struct packed {
    logic [CfgMsW-1:0] debounce_ms;
    logic [CfgMsW-1:0] click_min_ms;
    logic [CfgMsW-1:0] long_press_ms;
    logic              active_high;
  } cfg_t;

endpackage

// ===== hdl/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpc_pkg::CfgMsW-1:0]  cfg_wdata_i,
  output bpc_pkg::cfg_t             cfg_o
);
  import bpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:   cfg_d.debounce_ms   = cfg_wdata_i;
        CFG_CLICK_MIN:  cfg_d.click_min_ms  = cfg_wdata_i;
        CFG_LONG_PRESS: cfg_d.long_press_ms = cfg_wdata_i;
        CFG_ACTIVE_HI:  cfg_d.active_high   = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.click_min_ms  <= ClickMinRst;
      cfg_q.long_press_ms <= LongPressRst;
      cfg_q.active_high   <= ActiveHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bpc_classify.sv =====
module bpc_classify (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  bpc_pkg::in_item_t  item_i,
  input  bpc_pkg::cfg_t      cfg_i,
  output bpc_pkg::out_item_t res_o
);
  import bpc_pkg::*;

  logic [TimeW-1:0] last_change_q, last_change_d;
  logic [TimeW-1:0] last_press_q, last_press_d;
  press_state_e     state_q, state_d;

  logic [TimeW-1:0] since_change, since_press;
  logic             pressed;
  out_item_t        res;

  // Elapsed times wrap modulo the timestamp width.
  assign since_change = item_i.now_ms - last_change_q;
  assign since_press  = item_i.now_ms - last_press_q;
  assign pressed      = (item_i.pin_level == cfg_i.active_high);

  always_comb begin
    last_change_d     = last_change_q;
    last_press_d      = last_press_q;
    state_d           = state_q;
    res.down_event    = 1'b0;
    res.up_event      = 1'b0;
    res.click_event   = 1'b0;
    res.long_event    = 1'b0;
    if (!item_i.pin_changed) begin
      if ((state_q == ST_PRESSED) &&
          (since_press > {{(TimeW-CfgMsW){1'b0}}, cfg_i.long_press_ms})) begin
        state_d        = ST_LONG;
        res.long_event = 1'b1;
      end
    end else if (since_change > {{(TimeW-CfgMsW){1'b0}}, cfg_i.debounce_ms}) begin
      last_change_d = item_i.now_ms;
      if (pressed) begin
        last_press_d   = item_i.now_ms;
        state_d        = ST_PRESSED;
        res.down_event = 1'b1;
      end else begin
        res.up_event    = 1'b1;
        res.click_event = (state_q != ST_LONG) &&
                          (since_press > {{(TimeW-CfgMsW){1'b0}}, cfg_i.click_min_ms});
        state_d         = ST_RELEASED;
      end
    end
    case (state_d)
      ST_PRESSED: res.button_status = STATUS_PRESSED;
      ST_LONG:    res.button_status = STATUS_LONG;
      default:    res.button_status = STATUS_RELEASED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_change_q <= '0;
      last_press_q  <= '0;
      state_q       <= ST_RELEASED;
    end else if (fire_i) begin
      last_change_q <= last_change_d;
      last_press_q  <= last_press_d;
      state_q       <= state_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hdl/button_press_classifier.sv =====
// An accepted request is held in the input register (stage one); its result is written
// to the output register as the request leaves stage one, when the button state is updated.
// Throughput: one request per clock unless a result is held up at the output; the result
// register and the input register form a two-stage pipeline.
// Reset: asynchronous, active low; the registers return to debounce 50 ms, click 50 ms,
// long press 1000 ms, active low pin, and the button to released with both times zero.
module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bpc_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bpc_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgMsW-1:0]    cfg_wdata_i
);
  import bpc_pkg::*;

  // Stage one holds the accepted request; stage two holds its result.
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  cfg_t      cfg;
  out_item_t res;
  logic      advance;
  logic      in_take;

  // The request in stage one moves on whenever the result register is empty
  // or its current result is being taken in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  // Stage one refills as it empties, so a new request is taken every cycle
  // unless a finished result is held up at the output.
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The classifier's state is committed on the same edge as the result, so
  // the next request in stage one always sees the state left by this one.
  bpc_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_item_q;

`ifndef NO_ASSERTIONS
  // A long press can only be reported together with the long-pressed status.
  a_long_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.long_event |-> out_o.button_status == STATUS_LONG)
    else $error("long press reported without long status");

  // An accepted press leaves the button pressed and is never also a release.
  a_down_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.down_event |->
      out_o.button_status == STATUS_PRESSED && !out_o.up_event)
    else $error("press reported with wrong status");

  // A click only comes with a release, which always ends released.
  a_click_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.click_event |->
      out_o.up_event && out_o.button_status == STATUS_RELEASED)
    else $error("click without release");

  // With the result register empty the input side must never be held off.
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  // A long receiver hold-off has to stay well inside the watchdog limit. Every request
  // gives exactly one result, so the slowest correct run never goes without a handshake
  // for much longer than the hold-off.
  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 5000;
  localparam int ReqsPerPhase  = 250;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_req;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_res;
  logic      cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgMsW-1:0]  cfg_wdata;

  button_press_classifier i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the button state and the register set, kept in step with the block.
  cfg_t         btn_cfg = '{DebounceRst, ClickMinRst, LongPressRst, ActiveHighRst};
  logic [31:0]  last_change_ms = '0;
  logic [31:0]  last_press_ms = '0;
  press_state_e btn_state = ST_RELEASED;

  out_item_t pending_results[$];
  int        fail_count = 0;
  int        reqs_sent = 0;
  int        idle_cycles = 0;
  int        hold_at = -1;
  int        drain_at = -1;
  bit        hold_pending = 1'b0;
  bit        quiet_tail = 1'b0;

  // Works out the result of one request and moves the button state on. A pin change
  // that comes too soon after the last accepted one leaves everything as it was. All
  // elapsed times are taken modulo 2^32, so a timestamp that wraps still measures right.
  function automatic out_item_t classify_press(input in_item_t req);
    out_item_t   res;
    logic [31:0] since_press;
    logic [31:0] since_change;
    res          = '0;
    since_press  = req.now_ms - last_press_ms;
    since_change = req.now_ms - last_change_ms;
    if (!req.pin_changed) begin
      // A plain poll can only promote a held button to a long press, and only once.
      if (btn_state == ST_PRESSED && since_press > 32'(btn_cfg.long_press_ms)) begin
        btn_state       = ST_LONG;
        res.long_event  = 1'b1;
      end
    end else if (since_change > 32'(btn_cfg.debounce_ms)) begin
      last_change_ms = req.now_ms;
      if (req.pin_level == btn_cfg.active_high) begin
        // A press, even a second one in a row, restarts the hold time.
        last_press_ms  = req.now_ms;
        btn_state      = ST_PRESSED;
        res.down_event = 1'b1;
      end else begin
        // A release always reports up, even when the button was already released; the
        // click is measured from the last press, whenever that was.
        res.up_event    = 1'b1;
        res.click_event = (btn_state != ST_LONG) &&
                          (since_press > 32'(btn_cfg.click_min_ms));
        btn_state       = ST_RELEASED;
      end
    end
    case (btn_state)
      ST_PRESSED: res.button_status = STATUS_PRESSED;
      ST_LONG:    res.button_status = STATUS_LONG;
      default:    res.button_status = STATUS_RELEASED;
    endcase
    return res;
  endfunction

  // Idling comes and goes in stretches of requests, and stops altogether near the end.
  function automatic bit idling_allowed();
    return !quiet_tail && ((reqs_sent / 80) % 3 != 2);
  endfunction

  // Offers one request, optionally after a gap, and holds it until the block takes it.
  // The expected result is queued at the edge where the request is accepted; where the
  // directed table gives the result outright, that value is queued instead.
  task automatic send_req(input logic chg, input logic lvl, input logic [31:0] now_ms,
                          input bit known, input out_item_t known_res);
    in_item_t  req;
    out_item_t predicted;
    int        gap;
    req.pin_changed = chg;
    req.pin_level   = lvl;
    req.now_ms      = now_ms;
    @(negedge clk);
    if (idling_allowed() && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    predicted = classify_press(req);
    pending_results.push_back(known ? known_res : predicted);
    reqs_sent++;
  endtask

  // Stops offering requests and waits until every outstanding result has come back.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgMsW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEBOUNCE:   btn_cfg.debounce_ms   = val;
      CFG_CLICK_MIN:  btn_cfg.click_min_ms  = val;
      CFG_LONG_PRESS: btn_cfg.long_press_ms = val;
      default:        btn_cfg.active_high   = val[0];
    endcase
  endtask

  // Registers only change while the block is empty; the short pause covers the two
  // pipeline stages after the last result.
  task automatic set_config(input logic [CfgMsW-1:0] deb, input logic [CfgMsW-1:0] clk_min,
                            input logic [CfgMsW-1:0] lng, input logic [CfgMsW-1:0] act);
    drain_requests();
    repeat (4) @(posedge clk);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_CLICK_MIN, clk_min);
    write_reg(CFG_LONG_PRESS, lng);
    write_reg(CFG_ACTIVE_HI, act);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Picks the time to the next request. Many steps land close to the threshold that
  // matters next, so that both sides of each strict compare are hit; a few are tiny,
  // and now and then the clock jumps anywhere, which also exercises wrap-around.
  function automatic logic [31:0] pick_gap(input logic [CfgMsW-1:0] thr);
    case ($urandom_range(0, 9))
      0, 1:    return 32'($urandom_range(0, 3));
      2, 3, 4: return 32'(thr) + 32'($urandom_range(0, 4)) - 32'd2;
      5, 6:    return 32'(thr) + 32'($urandom_range(3, 200));
      7, 8:    return 32'($urandom_range(0, 2 * int'(thr) + 10));
      default: return $urandom();
    endcase
  endfunction

  // One phase under one register setting. Most of the traffic is press, hold, release
  // sequences with random timing; the rest is stray presses and releases and plain
  // noise. The pressure points fire at the request counts set before the phase.
  task automatic run_phase(input logic [CfgMsW-1:0] deb, input logic [CfgMsW-1:0] clk_min,
                           input logic [CfgMsW-1:0] lng, input logic [CfgMsW-1:0] act);
    int          first;
    int          polls;
    logic [31:0] t;
    logic        held_lvl;
    set_config(deb, clk_min, lng, act);
    first    = reqs_sent;
    held_lvl = act[0];
    t        = $urandom();
    while (reqs_sent - first < ReqsPerPhase) begin
      if (hold_at >= 0 && reqs_sent - first >= hold_at) begin
        hold_pending = 1'b1;
        hold_at      = -1;
      end
      if (drain_at >= 0 && reqs_sent - first >= drain_at) begin
        drain_requests();
        drain_at = -1;
      end
      if ($urandom_range(0, 6) == 0) begin
        send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? t + 32'($urandom_range(0, 100)) : $urandom(),
                 1'b0, '0);
      end else begin
        if ($urandom_range(0, 7) != 0) begin
          t += pick_gap(deb);
          send_req(1'b1, held_lvl, t, 1'b0, '0);
        end
        polls = $urandom_range(0, 4);
        repeat (polls) begin
          t += pick_gap(lng);
          send_req(1'b0, held_lvl ^ ($urandom_range(0, 7) == 0), t, 1'b0, '0);
        end
        if ($urandom_range(0, 7) == 0) begin
          t += pick_gap(deb);
          send_req(1'b1, held_lvl, t, 1'b0, '0);
        end
        t += pick_gap($urandom_range(0, 1) ? clk_min : deb);
        send_req(1'b1, !held_lvl, t, 1'b0, '0);
        if ($urandom_range(0, 7) == 0) begin
          t += pick_gap(deb);
          send_req(1'b1, !held_lvl, t, 1'b0, '0);
        end
      end
    end
  endtask

  // Directed requests, walked in order. Where the outcome is obvious the result is
  // written into the row; the rest are left to the predictor.
  typedef struct {
    logic        chg;
    logic        lvl;
    logic [31:0] now_ms;
    bit          known;
    out_item_t   res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_known(input logic chg, input logic lvl, input logic [31:0] now_ms,
                           input logic dn, input logic up, input logic clk_ev,
                           input logic lng, input logic [StatusW-1:0] status);
    dir_rows.push_back('{chg, lvl, now_ms, 1'b1, out_item_t'{dn, up, clk_ev, lng, status}});
  endtask

  task automatic add_checked(input logic chg, input logic lvl, input logic [31:0] now_ms);
    dir_rows.push_back('{chg, lvl, now_ms, 1'b0, out_item_t'('0)});
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request so that the
  // block fills up and has to stall its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: each result taken from the block is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.down_event !== want.down_event) begin
          $error("down_event: expected %0d, got %0d", want.down_event, out_res.down_event);
          fail_count++;
        end
        if (out_res.up_event !== want.up_event) begin
          $error("up_event: expected %0d, got %0d", want.up_event, out_res.up_event);
          fail_count++;
        end
        if (out_res.click_event !== want.click_event) begin
          $error("click_event: expected %0d, got %0d", want.click_event, out_res.click_event);
          fail_count++;
        end
        if (out_res.long_event !== want.long_event) begin
          $error("long_event: expected %0d, got %0d", want.long_event, out_res.long_event);
          fail_count++;
        end
        if (out_res.button_status !== want.button_status) begin
          $error("button_status: expected %0d, got %0d", want.button_status,
                 out_res.button_status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;

    // Reset settings: 50 ms debounce, 50 ms click, 1000 ms long press, pressed is low.
    // The first change lands exactly on the debounce time and must be ignored.
    add_known(1'b0, 1'b1, 32'd0,    1'b0, 1'b0, 1'b0, 1'b0, STATUS_RELEASED);
    add_known(1'b1, 1'b0, 32'd50,   1'b0, 1'b0, 1'b0, 1'b0, STATUS_RELEASED);
    add_known(1'b1, 1'b0, 32'd51,   1'b1, 1'b0, 1'b0, 1'b0, STATUS_PRESSED);
    // Held for exactly the long-press time is not yet long; one more ms is.
    add_known(1'b0, 1'b0, 32'd1051, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_PRESSED);
    add_known(1'b0, 1'b1, 32'd1052, 1'b0, 1'b0, 1'b0, 1'b1, STATUS_LONG);
    add_known(1'b0, 1'b0, 32'd3000, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_LONG);
    // Releasing a long press gives up but never a click.
    add_known(1'b1, 1'b1, 32'd3000, 1'b0, 1'b1, 1'b0, 1'b0, STATUS_RELEASED);
    // A release while already released still reports up, and here also a click.
    add_known(1'b1, 1'b1, 32'd3051, 1'b0, 1'b1, 1'b1, 1'b0, STATUS_RELEASED);
    add_known(1'b1, 1'b0, 32'd3102, 1'b1, 1'b0, 1'b0, 1'b0, STATUS_PRESSED);
    add_known(1'b1, 1'b1, 32'd3153, 1'b0, 1'b1, 1'b1, 1'b0, STATUS_RELEASED);
    // Pressing again restarts the hold time; a release right at debounce is ignored.
    add_checked(1'b1, 1'b0, 32'd3204);
    add_checked(1'b1, 1'b0, 32'd3300);
    add_checked(1'b1, 1'b1, 32'd3350);
    add_checked(1'b1, 1'b1, 32'd3351);
    // Hold times that straddle the wrap of the millisecond counter.
    add_checked(1'b1, 1'b0, 32'hFFFF_FFF0);
    add_checked(1'b0, 1'b0, 32'hFFFF_FFFF);
    add_checked(1'b0, 1'b0, 32'h0000_03D7);
    add_checked(1'b0, 1'b1, 32'h0000_03D9);
    add_checked(1'b1, 1'b1, 32'h0000_0040);
    add_checked(1'b1, 1'b0, 32'h7FFF_FFFF);
    add_checked(1'b1, 1'b1, 32'h8000_0040);
    add_checked(1'b1, 1'b1, 32'hFFFF_FFFF);
    add_checked(1'b0, 1'b1, 32'h0000_0000);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].chg, dir_rows[i].lvl, dir_rows[i].now_ms, dir_rows[i].known,
               dir_rows[i].res);
    end

    // Random phases, each under its own register setting, the extremes first. The
    // all-ones phase also carries the long receiver hold-off, and a later phase has
    // the sender pause mid-way until everything has come back.
    run_phase(16'd0, 16'd0, 16'd0, 16'd1);
    hold_at = 60;
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    drain_at = 120;
    run_phase(16'd10, 16'd30, 16'd200, 16'd1);
    // Only bit 0 of the polarity register counts; the upper bits are set here.
    run_phase(16'd3, 16'd5, 16'd20, 16'hFFFE);
    run_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)));
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    quiet_tail = 1'b1;
    run_phase(16'd20, 16'd40, 16'd100, 16'd0);

    drain_requests();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
